[rtl/d7s_pkg.sv]
package d7s_pkg;

  localparam int unsigned ValW  = 25;
  localparam int unsigned MagW  = 24;
  localparam int unsigned RcpW  = 25;
  localparam int unsigned ProdW = MagW + RcpW;
  localparam int unsigned IpW   = 14;
  localparam int unsigned FrW   = 10;
  localparam int unsigned Stages = 6;

  // mag / 1000 == (mag * ceil(2^34 / 1000)) >> 34 for mag < 2^24
  localparam logic [RcpW-1:0] RECIP_1000 = 25'd17179870;
  localparam int unsigned RcpShift = 34;

  localparam logic signed [ValW-1:0] VAL_HI = 25'sd10000000;
  localparam logic signed [ValW-1:0] VAL_LO = -25'sd1000000;

  localparam logic [7:0] SEG_BLANK = 8'h00;
  localparam logic [7:0] SEG_MINUS = 8'h40;
  localparam logic [7:0] SEG_E     = 8'h79;
  localparam logic [7:0] SEG_R     = 8'h50;
  localparam logic [7:0] SEG_DP    = 8'h80;

  typedef struct packed {
    logic       neg;
    logic       show_frac;
    logic [1:0] nf;
    logic [2:0] len;
  } d7s_ctrl_t;

  typedef logic [3:0] bcd_t;

  function automatic logic [7:0] seg_of(input bcd_t d);
    logic [7:0] s;
    case (d)
      4'd0:    s = 8'h3F;
      4'd1:    s = 8'h06;
      4'd2:    s = 8'h5B;
      4'd3:    s = 8'h4F;
      4'd4:    s = 8'h66;
      4'd5:    s = 8'h6D;
      4'd6:    s = 8'h7D;
      4'd7:    s = 8'h07;
      4'd8:    s = 8'h7F;
      4'd9:    s = 8'h6F;
      default: s = SEG_BLANK;
    endcase
    return s;
  endfunction

endpackage

[rtl/d7s_if.sv]
interface d7s_in_if;
  logic                valid;
  logic                ready;
  logic signed [24:0]  value_milli;

  modport source (output valid, output value_milli, input ready);
  modport sink   (input valid, input value_milli, output ready);
endinterface

interface d7s_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] digit_left;
  logic [7:0] digit_second;
  logic [7:0] digit_third;
  logic [7:0] digit_right;
  logic       out_of_range;

  modport source (output valid, output digit_left, output digit_second, output digit_third,
                  output digit_right, output out_of_range, input ready);
  modport sink   (input valid, input digit_left, input digit_second, input digit_third,
                  input digit_right, input out_of_range, output ready);
endinterface

[rtl/d7s_render.sv]
module d7s_render (
  input  d7s_pkg::d7s_ctrl_t       ctrl_i,
  input  d7s_pkg::bcd_t      [3:0] int_dig_i,   // [0] = ones
  input  d7s_pkg::bcd_t      [2:0] frac_dig_i,  // [0] = tenths
  output logic         [3:0] [7:0] seg_o        // [0] = rightmost
);
  import d7s_pkg::*;

  logic [2:0] sh;
  logic [2:0] top;

  always_comb begin
    sh  = ctrl_i.show_frac ? {1'b0, ctrl_i.nf} : 3'd0;
    top = sh + ctrl_i.len;
    for (int p = 0; p < 4; p++) begin
      seg_o[p] = SEG_BLANK;
      if (3'(p) < sh) begin
        seg_o[p] = seg_of(frac_dig_i[2'(ctrl_i.nf - 2'(p) - 2'd1)]);
      end else if (3'(p) < top) begin
        seg_o[p] = seg_of(int_dig_i[2'(3'(p) - sh)]);
        if (3'(p) == sh && ctrl_i.show_frac) begin
          seg_o[p] = seg_o[p] | SEG_DP;
        end
      end else if (ctrl_i.neg && 3'(p) == top) begin
        seg_o[p] = SEG_MINUS;
      end
    end
  end

endmodule

[rtl/decimal_to_seven_segment_formatter_top.sv]
// Throughput: one item per cycle while the output is not stalled; six register stages (sign/range, reciprocal
// multiply, remainder, digit quotients, digit split, segment render) share one ready chain.
// A waiting result holds the last stage; an earlier stage still loads while it is empty.
// Reset (rst_ni low, asynchronous) clears the stage valid bits; data regs are not reset.
module decimal_to_seven_segment_formatter_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  d7s_in_if.sink     in_i,
  d7s_out_if.source  out_o
);
  import d7s_pkg::*;

  logic [Stages-1:0] v_q;
  logic [Stages-1:0] en;

  always_comb begin
    en[Stages-1] = ~v_q[Stages-1] | out_o.ready;
    for (int k = Stages - 2; k >= 0; k--) begin
      en[k] = ~v_q[k] | en[k+1];
    end
  end

  assign in_i.ready = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_i.valid;
      end
      for (int k = 1; k < Stages; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // stage 1: range check and magnitude
  logic [ValW-1:0] abs_val;
  logic            neg1_q, err1_q;
  logic [MagW-1:0] mag1_q;

  assign abs_val = in_i.value_milli[ValW-1] ? ValW'(-in_i.value_milli)
                                            : ValW'(in_i.value_milli);

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      neg1_q <= in_i.value_milli[ValW-1];
      err1_q <= (in_i.value_milli >= VAL_HI) || (in_i.value_milli <= VAL_LO);
      mag1_q <= abs_val[MagW-1:0];
    end
  end

  // stage 2: reciprocal multiply for /1000
  logic             neg2_q, err2_q;
  logic [MagW-1:0]  mag2_q;
  logic [ProdW-1:0] prod2_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      neg2_q  <= neg1_q;
      err2_q  <= err1_q;
      mag2_q  <= mag1_q;
      prod2_q <= ProdW'(mag1_q) * ProdW'(RECIP_1000);
    end
  end

  // stage 3: integer part and remainder
  logic [IpW-1:0]  ip2;
  logic [MagW-1:0] rem2;
  logic            neg3_q, err3_q;
  logic [IpW-1:0]  ip3_q;
  logic [FrW-1:0]  fr3_q;

  assign ip2  = prod2_q[RcpShift+IpW-1:RcpShift];
  assign rem2 = mag2_q - MagW'(ip2) * MagW'(1000);

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      neg3_q <= neg2_q;
      err3_q <= err2_q;
      ip3_q  <= ip2;
      fr3_q  <= rem2[FrW-1:0];
    end
  end

  // stage 4: decimal quotients by reciprocal multiply
  logic [30:0] ipq10_p;
  logic [26:0] ipq100_p;
  logic [27:0] ipq1000_p;
  logic [17:0] frq10_p;
  logic [15:0] frq100_p;

  logic           neg4_q, err4_q;
  logic [IpW-1:0] ip4_q;
  logic [FrW-1:0] fr4_q;
  logic [9:0]     ipq10_q;
  logic [6:0]     ipq100_q;
  logic [3:0]     ipq1000_q;
  logic [6:0]     frq10_q;
  logic [3:0]     frq100_q;

  assign ipq10_p   = 31'(ip3_q) * 31'(52429);
  assign ipq100_p  = 27'(ip3_q) * 27'(5243);
  assign ipq1000_p = 28'(ip3_q) * 28'(8389);
  assign frq10_p   = 18'(fr3_q) * 18'(205);
  assign frq100_p  = 16'(fr3_q) * 16'(41);

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      neg4_q    <= neg3_q;
      err4_q    <= err3_q;
      ip4_q     <= ip3_q;
      fr4_q     <= fr3_q;
      ipq10_q   <= ipq10_p[28:19];
      ipq100_q  <= ipq100_p[25:19];
      ipq1000_q <= ipq1000_p[26:23];
      frq10_q   <= frq10_p[17:11];
      frq100_q  <= frq100_p[15:12];
    end
  end

  // stage 5: digit split and layout control
  logic [IpW-1:0] i0_w;
  logic [9:0]     i1_w;
  logic [6:0]     i2_w;
  logic [FrW-1:0] f0_w;
  logic [6:0]     f1_w;
  logic [2:0]     len5, avail5;
  logic [1:0]     nf5;
  logic           show5;

  assign i0_w = ip4_q - IpW'(ipq10_q) * IpW'(10);
  assign i1_w = ipq10_q - 10'(ipq100_q) * 10'(10);
  assign i2_w = ipq100_q - 7'(ipq1000_q) * 7'(10);
  assign f0_w = fr4_q - FrW'(frq10_q) * FrW'(10);
  assign f1_w = frq10_q - 7'(frq100_q) * 7'(10);

  always_comb begin
    if (ip4_q >= IpW'(1000)) begin
      len5 = 3'd4;
    end else if (ip4_q >= IpW'(100)) begin
      len5 = 3'd3;
    end else if (ip4_q >= IpW'(10)) begin
      len5 = 3'd2;
    end else begin
      len5 = 3'd1;
    end
    avail5 = neg4_q ? 3'd3 : 3'd4;
    nf5    = (len5 < avail5) ? 2'(avail5 - len5) : 2'd0;
    case (nf5)
      2'd3:    show5 = (fr4_q != '0);
      2'd2:    show5 = (frq10_q != '0);
      2'd1:    show5 = (frq100_q != '0);
      default: show5 = 1'b0;
    endcase
  end

  logic             err5_q;
  d7s_ctrl_t        ctrl5_q;
  bcd_t       [3:0] idig5_q;
  bcd_t       [2:0] fdig5_q;

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      err5_q            <= err4_q;
      ctrl5_q.neg       <= neg4_q;
      ctrl5_q.show_frac <= show5;
      ctrl5_q.nf        <= nf5;
      ctrl5_q.len       <= len5;
      idig5_q           <= {ipq1000_q, i2_w[3:0], i1_w[3:0], i0_w[3:0]};
      fdig5_q           <= {f0_w[3:0], f1_w[3:0], frq100_q};
    end
  end

  // stage 6: segment render into the output register
  logic [3:0][7:0] seg5;
  logic [3:0][7:0] seg6_q;
  logic            err6_q;

  d7s_render u_render (
    .ctrl_i     (ctrl5_q),
    .int_dig_i  (idig5_q),
    .frac_dig_i (fdig5_q),
    .seg_o      (seg5)
  );

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      err6_q <= err5_q;
      seg6_q <= err5_q ? {SEG_BLANK, SEG_E, SEG_R, SEG_R} : seg5;
    end
  end

  assign out_o.valid        = v_q[Stages-1];
  assign out_o.digit_left   = seg6_q[3];
  assign out_o.digit_second = seg6_q[2];
  assign out_o.digit_third  = seg6_q[1];
  assign out_o.digit_right  = seg6_q[0];
  assign out_o.out_of_range = err6_q;

  a_full_when_blocked : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (&v_q))
    else $error("input blocked while a pipeline stage is empty");

  a_rem_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[2] && !err3_q) |-> (fr3_q < FrW'(1000)))
    else $error("remainder of /1000 out of range");

  a_digit_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[4] && !err5_q) |-> (idig5_q[0] <= 4'd9 && idig5_q[1] <= 4'd9 &&
                            idig5_q[2] <= 4'd9 && idig5_q[3] <= 4'd9 &&
                            fdig5_q[0] <= 4'd9 && fdig5_q[1] <= 4'd9 &&
                            fdig5_q[2] <= 4'd9))
    else $error("decimal digit out of range");

  a_err_pattern : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[4] && en[5] && err5_q) |=> (out_o.out_of_range && out_o.digit_second == SEG_E))
    else $error("error item lost its error pattern");

endmodule
